// ----- rtl/erm_pkg.sv -----
// Shared constants, types and rounding helpers for the Euler rotation matrix core.
`timescale 1ns / 1ps

package erm_pkg;

  localparam int unsigned SC_STAGES  = 18;
  localparam int unsigned MX_STAGES  = 5;
  localparam int unsigned ERM_STAGES = SC_STAGES + MX_STAGES;
  localparam int unsigned SER_STEPS  = 6;

  localparam logic signed [17:0] FULL_TURN_S = 18'sd46080;
  localparam logic signed [17:0] DBL_TURN_S  = 18'sd92160;
  localparam logic [15:0] QUARTER_1 = 16'd11520;
  localparam logic [15:0] QUARTER_2 = 16'd23040;
  localparam logic [15:0] QUARTER_3 = 16'd34560;
  localparam logic [13:0] QUARTER_T = 14'd11520;
  localparam logic [13:0] EIGHTH_T  = 14'd5760;

  // pi*2^30 = 23040*146408 + 19106
  localparam logic [17:0] PI_WHOLE = 18'd146408;
  localparam logic [14:0] PI_FRAC  = 15'd19106;
  localparam logic [26:0] HALF_DIV = 27'd11520;
  localparam logic [18:0] RECIP45  = 19'(((64'd1 << 24) + 64'd44) / 64'd45);

  localparam logic [30:0] Q30_ONE  = 31'd1 << 30;
  localparam logic [60:0] Q30_HALF = 61'd1 << 29;

  localparam logic [31:0] COS_M [SER_STEPS] = '{
    32'(((64'd1 << 31) + 64'd1) / 64'd2),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 38) + 64'd131) / 64'd132)
  };
  localparam int unsigned COS_S [SER_STEPS] = '{31, 34, 35, 36, 37, 38};

  // sine has five terms; the sixth step adds zero
  localparam logic [31:0] SIN_M [SER_STEPS] = '{
    32'(((64'd1 << 33) + 64'd5) / 64'd6),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'd0
  };
  localparam int unsigned SIN_S [SER_STEPS] = '{33, 35, 36, 37, 37, 31};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } erm_quad_e;

  typedef struct packed {
    erm_quad_e quad;
    logic      swap;
  } erm_oct_t;

  // Q60 product back to Q30, half away from zero
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [33:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = mag + 64'(Q30_HALF);
    r   = mag[63:30];
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Q30 to Q14, half away from zero, saturated to +-1.0
  function automatic logic [15:0] to_q14(input logic signed [33:0] v);
    logic [33:0] mag;
    logic [17:0] r;
    mag = v[33] ? 34'(-v) : 34'(v);
    mag = mag + 34'd32768;
    r   = mag[33:16];
    if (r > 18'd16384) begin
      r = 18'd16384;
    end
    return v[33] ? 16'(-r) : 16'(r);
  endfunction

endpackage

// ----- rtl/erm_sincos.sv -----
// Pipelined sine and cosine of one angle, Q30 outputs.
`timescale 1ns / 1ps

module erm_sincos (
  input  logic                                clk_i,
  input  logic [erm_pkg::SC_STAGES-1:0]       en_i,
  input  logic signed [16:0]                  angle_i,
  output logic signed [31:0]                  sin_o,
  output logic signed [31:0]                  cos_o
);

  logic signed [17:0] v;
  logic [15:0]        a_d, a_q;
  logic [13:0]        t;
  logic [12:0]        tt_d, tt_q;
  erm_pkg::erm_oct_t  oct_d;
  erm_pkg::erm_oct_t  oct_q [1:16];
  logic [29:0]        hi_q;
  logic [26:0]        lo_q;
  logic [36:0]        qd_p;
  logic [29:0]        th_d, th_q, th4_q, th2_q;
  logic [60:0]        sq;

  logic [30:0]        ct_in [erm_pkg::SER_STEPS];
  logic [30:0]        st_in [erm_pkg::SER_STEPS];
  logic signed [31:0] ca_in [erm_pkg::SER_STEPS];
  logic signed [31:0] sa_in [erm_pkg::SER_STEPS];
  logic [29:0]        t2_in [erm_pkg::SER_STEPS];
  logic [60:0]        pcm [erm_pkg::SER_STEPS];
  logic [60:0]        psm [erm_pkg::SER_STEPS];
  logic [61:0]        qcm [erm_pkg::SER_STEPS];
  logic [61:0]        qsm [erm_pkg::SER_STEPS];
  logic [30:0]        qc [erm_pkg::SER_STEPS];
  logic [30:0]        qs [erm_pkg::SER_STEPS];
  logic signed [31:0] cacc_d [erm_pkg::SER_STEPS];
  logic signed [31:0] sacc_d [erm_pkg::SER_STEPS];

  logic [29:0]        pc_q [erm_pkg::SER_STEPS];
  logic [29:0]        ps_q [erm_pkg::SER_STEPS];
  logic signed [31:0] cacc_a_q [erm_pkg::SER_STEPS];
  logic signed [31:0] sacc_a_q [erm_pkg::SER_STEPS];
  logic [29:0]        th2_a_q [erm_pkg::SER_STEPS];
  logic [30:0]        ct_q [erm_pkg::SER_STEPS];
  logic [30:0]        st_q [erm_pkg::SER_STEPS];
  logic signed [31:0] cacc_b_q [erm_pkg::SER_STEPS];
  logic signed [31:0] sacc_b_q [erm_pkg::SER_STEPS];
  logic [29:0]        th2_b_q [erm_pkg::SER_STEPS];

  logic signed [31:0] ls, lc, sin_d, cos_d, sin_q, cos_q;

  // wrap to one turn
  always_comb begin
    v = {angle_i[16], angle_i};
    if (v < -erm_pkg::FULL_TURN_S) begin
      a_d = 16'(v + erm_pkg::DBL_TURN_S);
    end else if (v < 18'sd0) begin
      a_d = 16'(v + erm_pkg::FULL_TURN_S);
    end else if (v >= erm_pkg::FULL_TURN_S) begin
      a_d = 16'(v - erm_pkg::FULL_TURN_S);
    end else begin
      a_d = 16'(v);
    end
  end

  // quadrant and octant fold
  always_comb begin
    priority if (a_q >= erm_pkg::QUARTER_3) begin
      oct_d.quad = erm_pkg::QUAD_3;
      t = 14'(a_q - erm_pkg::QUARTER_3);
    end else if (a_q >= erm_pkg::QUARTER_2) begin
      oct_d.quad = erm_pkg::QUAD_2;
      t = 14'(a_q - erm_pkg::QUARTER_2);
    end else if (a_q >= erm_pkg::QUARTER_1) begin
      oct_d.quad = erm_pkg::QUAD_1;
      t = 14'(a_q - erm_pkg::QUARTER_1);
    end else begin
      oct_d.quad = erm_pkg::QUAD_0;
      t = a_q[13:0];
    end
    oct_d.swap = t > erm_pkg::EIGHTH_T;
    tt_d = oct_d.swap ? 13'(erm_pkg::QUARTER_T - t) : t[12:0];
  end

  // radians: whole part plus frac / 23040 rounded to nearest, 23040 = 512 * 45
  always_comb begin
    qd_p = lo_q[26:9] * erm_pkg::RECIP45;
    th_d = hi_q + 30'(qd_p[36:24]);
    sq   = th_q * th_q + erm_pkg::Q30_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q <= a_d;
    end
    if (en_i[1]) begin
      tt_q     <= tt_d;
      oct_q[1] <= oct_d;
    end
    if (en_i[2]) begin
      hi_q <= 30'(tt_q * erm_pkg::PI_WHOLE);
      lo_q <= 27'(tt_q * erm_pkg::PI_FRAC) + erm_pkg::HALF_DIV;
    end
    if (en_i[3]) begin
      th_q <= th_d;
    end
    if (en_i[4]) begin
      th4_q <= th_q;
      th2_q <= sq[59:30];
    end
    for (int k = 2; k <= 16; k++) begin
      if (en_i[k]) begin
        oct_q[k] <= oct_q[k-1];
      end
    end
  end

  // Taylor series, two stages per term
  always_comb begin
    ct_in[0] = erm_pkg::Q30_ONE;
    st_in[0] = {1'b0, th4_q};
    ca_in[0] = $signed({1'b0, erm_pkg::Q30_ONE});
    sa_in[0] = $signed({2'b00, th4_q});
    t2_in[0] = th2_q;
    for (int j = 1; j < erm_pkg::SER_STEPS; j++) begin
      ct_in[j] = ct_q[j-1];
      st_in[j] = st_q[j-1];
      ca_in[j] = cacc_b_q[j-1];
      sa_in[j] = sacc_b_q[j-1];
      t2_in[j] = th2_b_q[j-1];
    end
    for (int j = 0; j < erm_pkg::SER_STEPS; j++) begin
      pcm[j] = ct_in[j] * t2_in[j];
      psm[j] = st_in[j] * t2_in[j];
      qcm[j] = pc_q[j] * erm_pkg::COS_M[j];
      qsm[j] = ps_q[j] * erm_pkg::SIN_M[j];
      qc[j]  = 31'(qcm[j] >> erm_pkg::COS_S[j]);
      qs[j]  = 31'(qsm[j] >> erm_pkg::SIN_S[j]);
      if ((j % 2) == 0) begin
        cacc_d[j] = cacc_a_q[j] - $signed({1'b0, qc[j]});
        sacc_d[j] = sacc_a_q[j] - $signed({1'b0, qs[j]});
      end else begin
        cacc_d[j] = cacc_a_q[j] + $signed({1'b0, qc[j]});
        sacc_d[j] = sacc_a_q[j] + $signed({1'b0, qs[j]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < erm_pkg::SER_STEPS; j++) begin
      if (en_i[5+2*j]) begin
        pc_q[j]     <= pcm[j][59:30];
        ps_q[j]     <= psm[j][59:30];
        cacc_a_q[j] <= ca_in[j];
        sacc_a_q[j] <= sa_in[j];
        th2_a_q[j]  <= t2_in[j];
      end
      if (en_i[6+2*j]) begin
        ct_q[j]     <= qc[j];
        st_q[j]     <= qs[j];
        cacc_b_q[j] <= cacc_d[j];
        sacc_b_q[j] <= sacc_d[j];
        th2_b_q[j]  <= th2_a_q[j];
      end
    end
  end

  // undo octant fold and apply quadrant
  always_comb begin
    ls = oct_q[16].swap ? cacc_b_q[erm_pkg::SER_STEPS-1] : sacc_b_q[erm_pkg::SER_STEPS-1];
    lc = oct_q[16].swap ? sacc_b_q[erm_pkg::SER_STEPS-1] : cacc_b_q[erm_pkg::SER_STEPS-1];
    unique case (oct_q[16].quad)
      erm_pkg::QUAD_0: begin
        sin_d = ls;
        cos_d = lc;
      end
      erm_pkg::QUAD_1: begin
        sin_d = lc;
        cos_d = -ls;
      end
      erm_pkg::QUAD_2: begin
        sin_d = -ls;
        cos_d = -lc;
      end
      default: begin
        sin_d = -lc;
        cos_d = ls;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[erm_pkg::SC_STAGES-1]) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- rtl/erm_matrix.sv -----
// Pipelined X*Y*Z matrix product with Q14 rounding and saturation.
`timescale 1ns / 1ps

module erm_matrix (
  input  logic                            clk_i,
  input  logic [erm_pkg::MX_STAGES-1:0]   en_i,
  input  logic signed [31:0]              sx_i,
  input  logic signed [31:0]              cx_i,
  input  logic signed [31:0]              sy_i,
  input  logic signed [31:0]              cy_i,
  input  logic signed [31:0]              sz_i,
  input  logic signed [31:0]              cz_i,
  output logic [8:0][15:0]                m_o
);

  logic signed [63:0] sxsy_q, sxcy_q, cxsy_q, cxcy_q, cycz_q, cysz_q;
  logic signed [63:0] cxsz_q, cxcz_q, sxsz_q, sxcz_q;
  logic signed [31:0] sy1_q, sz1_q, cz1_q, sz2_q, cz2_q;

  logic signed [33:0] a_q, b_q, c_q, d_q, m0_q, m1_q, m2_q;
  logic signed [33:0] u3_q, u4_q, u6_q, u7_q;

  logic signed [63:0] acz_q, asz_q, ccz_q, csz_q;
  logic signed [33:0] b2_q, d2_q, m02_q, m12_q, m22_q;
  logic signed [33:0] u32_q, u42_q, u62_q, u72_q;

  logic signed [33:0] r_q [9];
  logic [15:0]        out_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sxsy_q <= sx_i * sy_i;
      sxcy_q <= sx_i * cy_i;
      cxsy_q <= cx_i * sy_i;
      cxcy_q <= cx_i * cy_i;
      cycz_q <= cy_i * cz_i;
      cysz_q <= cy_i * sz_i;
      cxsz_q <= cx_i * sz_i;
      cxcz_q <= cx_i * cz_i;
      sxsz_q <= sx_i * sz_i;
      sxcz_q <= sx_i * cz_i;
      sy1_q  <= sy_i;
      sz1_q  <= sz_i;
      cz1_q  <= cz_i;
    end
    if (en_i[1]) begin
      a_q   <= -erm_pkg::rnd30(sxsy_q);
      b_q   <= -erm_pkg::rnd30(sxcy_q);
      c_q   <= erm_pkg::rnd30(cxsy_q);
      d_q   <= erm_pkg::rnd30(cxcy_q);
      m0_q  <= erm_pkg::rnd30(cycz_q);
      m1_q  <= erm_pkg::rnd30(cysz_q);
      m2_q  <= -34'(sy1_q);
      u3_q  <= erm_pkg::rnd30(cxsz_q);
      u4_q  <= erm_pkg::rnd30(cxcz_q);
      u6_q  <= erm_pkg::rnd30(sxsz_q);
      u7_q  <= erm_pkg::rnd30(sxcz_q);
      sz2_q <= sz1_q;
      cz2_q <= cz1_q;
    end
    if (en_i[2]) begin
      acz_q <= a_q * cz2_q;
      asz_q <= a_q * sz2_q;
      ccz_q <= c_q * cz2_q;
      csz_q <= c_q * sz2_q;
      b2_q  <= b_q;
      d2_q  <= d_q;
      m02_q <= m0_q;
      m12_q <= m1_q;
      m22_q <= m2_q;
      u32_q <= u3_q;
      u42_q <= u4_q;
      u62_q <= u6_q;
      u72_q <= u7_q;
    end
    if (en_i[3]) begin
      r_q[0] <= m02_q;
      r_q[1] <= m12_q;
      r_q[2] <= m22_q;
      r_q[3] <= erm_pkg::rnd30(acz_q) - u32_q;
      r_q[4] <= erm_pkg::rnd30(asz_q) + u42_q;
      r_q[5] <= b2_q;
      r_q[6] <= erm_pkg::rnd30(ccz_q) - u62_q;
      r_q[7] <= erm_pkg::rnd30(csz_q) + u72_q;
      r_q[8] <= d2_q;
    end
    if (en_i[4]) begin
      for (int i = 0; i < 9; i++) begin
        out_q[i] <= erm_pkg::to_q14(r_q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m_o[i] = out_q[i];
    end
  end

endmodule

// ----- rtl/euler_rotation_matrix_core.sv -----
// Top level: three sine/cosine lanes, matrix product and pipeline flow control.
`timescale 1ns / 1ps

// Takes three angles (1/128 degree, any 17-bit value, wrapped to one turn) and
// returns the nine entries of the X*Y*Z rotation matrix in Q2.14, rounded and
// saturated to +-1.0. The pipeline is 23 stages deep, and one request can be
// accepted every cycle unless in_stall_o is high. Most of the depth is the
// Taylor series (two stages per term, six terms); the rest is angle reduction
// and the two rounds of matrix products with Q14 rounding. Each stage
// advances when it is empty or the stage after it advances, so bubbles are
// squeezed out and requests keep entering while a result waits at the output.

module euler_rotation_matrix_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [16:0] angle_x_i,
  input  logic signed [16:0] angle_y_i,
  input  logic signed [16:0] angle_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o
);

  localparam int unsigned Last = erm_pkg::ERM_STAGES - 1;

  logic [erm_pkg::ERM_STAGES-1:0] vld_d, vld_q, en;
  logic signed [31:0]             sx, cx, sy, cy, sz, cz;
  logic [8:0][15:0]               m;

  always_comb begin
    en[Last] = !vld_q[Last] || !out_stall_i;
    for (int i = int'(Last) - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i <= int'(Last); i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  erm_sincos u_sc_x (
    .clk_i   (clk_i),
    .en_i    (en[erm_pkg::SC_STAGES-1:0]),
    .angle_i (angle_x_i),
    .sin_o   (sx),
    .cos_o   (cx)
  );

  erm_sincos u_sc_y (
    .clk_i   (clk_i),
    .en_i    (en[erm_pkg::SC_STAGES-1:0]),
    .angle_i (angle_y_i),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  erm_sincos u_sc_z (
    .clk_i   (clk_i),
    .en_i    (en[erm_pkg::SC_STAGES-1:0]),
    .angle_i (angle_z_i),
    .sin_o   (sz),
    .cos_o   (cz)
  );

  erm_matrix u_mx (
    .clk_i (clk_i),
    .en_i  (en[erm_pkg::ERM_STAGES-1:erm_pkg::SC_STAGES]),
    .sx_i  (sx),
    .cx_i  (cx),
    .sy_i  (sy),
    .cy_i  (cy),
    .sz_i  (sz),
    .cz_i  (cz),
    .m_o   (m)
  );

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[Last];
  assign m00_o = $signed(m[0]);
  assign m01_o = $signed(m[1]);
  assign m02_o = $signed(m[2]);
  assign m10_o = $signed(m[3]);
  assign m11_o = $signed(m[4]);
  assign m12_o = $signed(m[5]);
  assign m20_o = $signed(m[6]);
  assign m21_o = $signed(m[7]);
  assign m22_o = $signed(m[8]);

`ifndef NO_ASSERTIONS
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  a_drain_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted request not in first stage");

  a_out_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m00_o <= 16'sd16384) && (m00_o >= -16'sd16384)
                 && (m22_o <= 16'sd16384) && (m22_o >= -16'sd16384))
    else $error("matrix entry outside +-1.0");
`endif

endmodule

// ----- tb/sv/euler_rotation_matrix_core_tb.sv -----
// Testbench for the Euler rotation matrix core: table and random angles checked against a predictor.
`timescale 1ns / 1ps

module euler_rotation_matrix_core_tb;

  typedef struct {
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] az;
    bit                 known;
    logic signed [15:0] m [9];
  } row_t;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [16:0] angle_x_i;
  logic signed [16:0] angle_y_i;
  logic signed [16:0] angle_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  matrix_t     matrix_q[$];
  row_t        dir_rows[$];
  int unsigned errors;
  int unsigned cycles;
  bit          hold_off;
  bit          pause_done;

  euler_rotation_matrix_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .angle_x_i   (angle_x_i),
    .angle_y_i   (angle_y_i),
    .angle_z_i   (angle_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .m00_o       (m00_o),
    .m01_o       (m01_o),
    .m02_o       (m02_o),
    .m10_o       (m10_o),
    .m11_o       (m11_o),
    .m12_o       (m12_o),
    .m20_o       (m20_o),
    .m21_o       (m21_o),
    .m22_o       (m22_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint rnd_shift(input longint v, input int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return rnd_shift(a * b, 30);
  endfunction

  function automatic void local_trig(input int t, output longint s, output longint c);
    longint unsigned th, th2, term;
    longint acc;
    th = (longint'(t) * 64'd3373259426 + 64'd11520) / 64'd23040;
    th2 = (th * th + (64'd1 << 29)) >> 30;
    term = th;
    acc = th;
    for (int n = 1; n <= 5; n++) begin
      term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
      acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
    end
    s = acc;
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * th2) >> 30) / ((2 * n - 1) * (2 * n));
      acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
    end
    c = acc;
  endfunction

  function automatic void angle_trig(input logic signed [16:0] ang, output longint s,
                                     output longint c);
    int a, q, t;
    longint ls, lc;
    a = int'(ang) % 46080;
    if (a < 0) a += 46080;
    q = a / 11520;
    t = a % 11520;
    if (t > 5760) local_trig(11520 - t, lc, ls);
    else local_trig(t, ls, lc);
    case (q)
      0: begin s = ls; c = lc; end
      1: begin s = lc; c = -ls; end
      2: begin s = -ls; c = -lc; end
      default: begin s = -lc; c = ls; end
    endcase
  endfunction

  function automatic logic signed [15:0] q14_sat(input longint v);
    longint r;
    r = rnd_shift(v, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic matrix_t rotation(input logic signed [16:0] ax,
                                       input logic signed [16:0] ay,
                                       input logic signed [16:0] az);
    longint sx, cx, sy, cy, sz, cz, a, b, c, d;
    longint e [9];
    matrix_t r;
    angle_trig(ax, sx, cx);
    angle_trig(ay, sy, cy);
    angle_trig(az, sz, cz);
    a = -qmul(sx, sy);
    b = -qmul(sx, cy);
    c = qmul(cx, sy);
    d = qmul(cx, cy);
    e[0] = qmul(cy, cz);
    e[1] = qmul(cy, sz);
    e[2] = -sy;
    e[3] = qmul(a, cz) - qmul(cx, sz);
    e[4] = qmul(a, sz) + qmul(cx, cz);
    e[5] = b;
    e[6] = qmul(c, cz) - qmul(sx, sz);
    e[7] = qmul(c, sz) + qmul(sx, cz);
    e[8] = d;
    for (int i = 0; i < 9; i++) r.m[i] = q14_sat(e[i]);
    return r;
  endfunction

  function automatic void add_row(input int ax, input int ay, input int az, input bit known,
                                  input int k0, input int k1, input int k2, input int k3,
                                  input int k4, input int k5, input int k6, input int k7,
                                  input int k8);
    row_t r;
    r.ax = 17'(ax);
    r.ay = 17'(ay);
    r.az = 17'(az);
    r.known = known;
    r.m = '{16'(k0), 16'(k1), 16'(k2), 16'(k3), 16'(k4), 16'(k5), 16'(k6), 16'(k7),
            16'(k8)};
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [16:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 17'($urandom);
      1: return 17'(11520 * $signed($urandom_range(0, 8)) - 46080);
      2: return 17'(5760 + $signed($urandom_range(0, 4)) - 2);
      default: return 17'($signed($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  task automatic send(input logic signed [16:0] ax, input logic signed [16:0] ay,
                      input logic signed [16:0] az, input bit known,
                      input logic signed [15:0] km [9]);
    matrix_t e;
    e = rotation(ax, ay, az);
    if (known) e.m = km;
    in_valid_i <= 1'b1;
    angle_x_i  <= ax;
    angle_y_i  <= ay;
    angle_z_i  <= az;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    matrix_q.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic gap();
    in_valid_i <= 1'b0;
    angle_x_i  <= 17'($urandom);
    angle_y_i  <= 17'($urandom);
    angle_z_i  <= 17'($urandom);
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 200000) begin
        $display("euler_rotation_matrix_core_tb failed");
        $finish;
      end
    end
  end

  // receiver: stall pattern, plus long hold-offs when the stimulus asks for them
  initial begin
    int mode;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (80) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        mode = (cycles / 300) % 3;
        if (mode == 0) out_stall_i <= 1'b0;
        else if (mode == 1) out_stall_i <= ($urandom_range(0, 3) == 0);
        else out_stall_i <= ((cycles % 7) < 3);
      end
    end
  end

  always @(posedge clk_i) begin
    matrix_t e;
    logic signed [15:0] got [9];
    string nm [9];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      nm = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
      if (matrix_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = matrix_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== e.m[i]) begin
            $error("%s: expected %0d, got %0d", nm[i], e.m[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic signed [15:0] none [9];
    int burst, w;
    errors     = 0;
    hold_off   = 1'b0;
    pause_done = 1'b0;
    none = '{default: '0};
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    angle_x_i  = '0;
    angle_y_i  = '0;
    angle_z_i  = '0;
    add_row(0, 0, 0, 1, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    add_row(46080, -46080, 46080, 1, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    add_row(11520, 0, 0, 1, 16384, 0, 0, 0, 0, -16384, 0, 16384, 0);
    add_row(0, 11520, 0, 1, 0, 0, -16384, 0, 16384, 0, 16384, 0, 0);
    add_row(0, 0, 11520, 1, 0, 16384, 0, -16384, 0, 0, 0, 0, 16384);
    add_row(23040, 0, 0, 1, 16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    add_row(0, -11520, 0, 1, 0, 0, 16384, 0, 16384, 0, -16384, 0, 0);
    add_row(-65536, -65536, -65536, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(65535, 65535, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(5760, 5760, 5760, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(5761, 5759, 17281, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, -1, 46079, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-46079, 34560, -34560, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(21845, -21846, 43690, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(-11520, -23040, -5760, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) send(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az,
                               dir_rows[i].known, dir_rows[i].m);
    for (int n = 0; n < 1700; n += burst) begin
      burst = $urandom_range(1, 40);
      if (n >= 400 && !hold_off && !pause_done) hold_off = 1'b1;
      if (n >= 900 && !pause_done) begin
        pause_done = 1'b1;
        in_valid_i <= 1'b0;
        while (matrix_q.size() != 0) @(negedge clk_i);
      end
      for (int k = 0; k < burst; k++) send(rand_angle(), rand_angle(), rand_angle(), 0, none);
      if ($urandom_range(0, 2) != 0) gap();
    end
    in_valid_i <= 1'b0;
    w = 0;
    while (matrix_q.size() != 0 && w < 20000) begin
      @(negedge clk_i);
      w++;
    end
    repeat (40) @(negedge clk_i);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("euler_rotation_matrix_core_tb passed");
    end else begin
      $display("euler_rotation_matrix_core_tb failed");
    end
    $finish;
  end

endmodule
